// ===== design/rba_pkg.sv =====
// Shared types and constants for the reference-counted block allocator.
// Used by rba_ctrl, rba_datapath and refcount_block_allocator; no dependencies.
package rba_pkg;

  localparam int DEF_MAX_BLOCKS = 1024;
  localparam int DEF_COUNT_BITS = 32;

  localparam int REQ_W = 3;
  localparam int IDX_W = 10;
  localparam int CNT_W = 32;
  localparam int ST_W  = 3;
  localparam int BIU_W = 11;

  localparam logic [BIU_W-1:0] BIU_RESET = 11'd1024;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC = 3'd0,
    REQ_INC   = 3'd1,
    REQ_DEC   = 3'd2,
    REQ_READ  = 3'd3,
    REQ_SET   = 3'd4
  } req_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_RANGE   = 3'd1,
    ST_NOSPACE = 3'd2,
    ST_UNDER   = 3'd3,
    ST_OVER    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RMW,
    S_SCAN,
    S_SHRINK
  } state_t;

  typedef struct packed {
    logic clr_en;
    logic accept;
    logic cfg_wr;
    logic rmw;
    logic scan;
    logic sweep;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_done;
    logic sweep_done;
    logic shrink;
    logic alloc_req;
    logic pend_valid;
  } dp_status_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] blk;
    logic [CNT_W-1:0] cnt;
    logic             shared;
    logic [BIU_W-1:0] free;
  } res_t;

endpackage

// ===== design/rba_ctrl.sv =====
// Controller state machine for the block allocator.
// Depends on rba_pkg; drives the datapath commands and the stall and ready outputs.
module rba_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                cfg_valid,
  input  rba_pkg::dp_status_t sts,
  output rba_pkg::dp_cmd_t    cmd,
  output logic                in_stall,
  output logic                cfg_ready
);
  import rba_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    cfg_ready  = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cfg_ready = 1'b1;
        in_stall  = cfg_valid || sts.pend_valid;
        if (cfg_valid) begin
          cmd.cfg_wr = 1'b1;
          if (sts.shrink) begin
            state_next = S_SHRINK;
          end
        end else if (in_valid && !sts.pend_valid) begin
          cmd.accept = 1'b1;
          state_next = sts.alloc_req ? S_SCAN : S_RMW;
        end
      end
      S_RMW: begin
        cmd.rmw    = 1'b1;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = S_IDLE;
        end
      end
      S_SHRINK: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/rba_datapath.sv =====
// Datapath of the block allocator: count memory, hint, used count and result registers.
// Depends on rba_pkg; sequenced by rba_ctrl through dp_cmd_t and dp_status_t.
module rba_datapath #(
  parameter int MAX_BLOCKS = rba_pkg::DEF_MAX_BLOCKS,
  parameter int COUNT_BITS = rba_pkg::DEF_COUNT_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  rba_pkg::dp_cmd_t           cmd,
  output rba_pkg::dp_status_t        sts,
  input  logic [rba_pkg::BIU_W-1:0]  blocks_in_use,
  input  logic [rba_pkg::REQ_W-1:0]  req_type,
  input  logic [rba_pkg::IDX_W-1:0]  block_index,
  input  logic [rba_pkg::CNT_W-1:0]  new_count,
  input  logic                       out_stall,
  output logic                       out_valid,
  output rba_pkg::res_t              out_res
);
  import rba_pkg::*;

  localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int NW = $clog2(MAX_BLOCKS + 1);
  localparam int LW = (NW > BIU_W) ? NW : BIU_W;

  logic [COUNT_BITS-1:0] mem [MAX_BLOCKS];
  logic [COUNT_BITS-1:0] rdata;

  logic [BIU_W-1:0]      bin;
  logic [NW-1:0]         hint;
  logic [NW-1:0]         used;
  logic [NW-1:0]         ptr;
  logic [NW-1:0]         lim;
  logic                  chk_valid;
  logic [AW-1:0]         chk_addr;
  logic [REQ_W-1:0]      rq_type;
  logic [IDX_W-1:0]      rq_b;
  logic [COUNT_BITS-1:0] rq_nc;
  logic                  pend_valid;
  res_t                  pend_res;

  logic [LW-1:0]         max_ext;
  logic [LW-1:0]         bin_ext;
  logic [LW-1:0]         n_ext;
  logic [LW-1:0]         cfg_ext;
  logic [LW-1:0]         new_n_ext;
  logic [LW-1:0]         b_ext;
  logic [LW-1:0]         port_b_ext;
  logic [LW-1:0]         chk_ext;
  logic [LW-1:0]         free_full;
  logic                  found;
  logic                  ptr_at_n;
  logic                  ptr_at_lim;
  logic                  b_in_range;
  logic                  take;
  logic [AW-1:0]         raddr;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [COUNT_BITS-1:0] wdata;
  logic [NW-1:0]         hint_next;
  logic [NW-1:0]         used_next;
  logic                  fin;
  res_t                  res;
  logic [COUNT_BITS-1:0] c_new;

  assign max_ext    = LW'(MAX_BLOCKS);
  assign bin_ext    = LW'(bin);
  assign n_ext      = (bin_ext > max_ext) ? max_ext : bin_ext;
  assign cfg_ext    = LW'(blocks_in_use);
  assign new_n_ext  = (cfg_ext > max_ext) ? max_ext : cfg_ext;
  assign b_ext      = LW'(rq_b);
  assign port_b_ext = LW'(block_index);
  assign chk_ext    = LW'(chk_addr);
  assign found      = chk_valid && (rdata == '0);
  assign ptr_at_n   = LW'(ptr) >= n_ext;
  assign ptr_at_lim = ptr >= lim;
  assign b_in_range = b_ext < n_ext;
  assign take       = out_valid && !out_stall;

  assign sts.clr_last   = ptr == NW'(MAX_BLOCKS - 1);
  assign sts.scan_done  = found || ptr_at_n;
  assign sts.sweep_done = ptr_at_lim;
  assign sts.shrink     = new_n_ext < n_ext;
  assign sts.alloc_req  = req_type == REQ_ALLOC;
  assign sts.pend_valid = pend_valid;

  always_comb begin
    if (cmd.scan || cmd.sweep || cmd.clr_en) begin
      raddr = ptr[AW-1:0];
    end else if (cmd.rmw) begin
      raddr = b_ext[AW-1:0];
    end else begin
      raddr = port_b_ext[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    we        = 1'b0;
    waddr     = ptr[AW-1:0];
    wdata     = '0;
    hint_next = hint;
    used_next = used;
    fin       = 1'b0;
    res       = '0;
    c_new     = '0;
    if (cmd.clr_en) begin
      we = 1'b1;
    end
    if (cmd.sweep && chk_valid && (rdata != '0)) begin
      we        = 1'b1;
      waddr     = chk_addr;
      used_next = used - NW'(1);
    end
    if (cmd.scan) begin
      if (found) begin
        we         = 1'b1;
        waddr      = chk_addr;
        wdata      = COUNT_BITS'(1);
        hint_next  = NW'(chk_addr) + NW'(1);
        used_next  = used + NW'(1);
        fin        = 1'b1;
        res.status = ST_OK;
        res.blk    = chk_ext[IDX_W-1:0];
        res.cnt    = CNT_W'(1);
      end else if (ptr_at_n) begin
        fin        = 1'b1;
        res.status = ST_NOSPACE;
      end
    end
    if (cmd.rmw) begin
      fin        = 1'b1;
      res.status = ST_OK;
      res.blk    = rq_b;
      waddr      = b_ext[AW-1:0];
      case (rq_type)
        REQ_INC, REQ_DEC, REQ_READ, REQ_SET: begin
          if (!b_in_range) begin
            res.status = ST_RANGE;
          end else begin
            c_new = rdata;
            case (rq_type)
              REQ_INC: begin
                if (rdata == '1) begin
                  res.status = ST_OVER;
                end else begin
                  c_new = rdata + COUNT_BITS'(1);
                  we    = 1'b1;
                  if (rdata == '0) begin
                    used_next = used + NW'(1);
                  end
                end
              end
              REQ_DEC: begin
                if (rdata == '0) begin
                  res.status = ST_UNDER;
                end else begin
                  c_new = rdata - COUNT_BITS'(1);
                  we    = 1'b1;
                  if (rdata == COUNT_BITS'(1)) begin
                    used_next = used - NW'(1);
                    if (LW'(hint) > b_ext) begin
                      hint_next = b_ext[NW-1:0];
                    end
                  end
                end
              end
              REQ_SET: begin
                c_new = rq_nc;
                we    = 1'b1;
                if ((rdata == '0) && (rq_nc != '0)) begin
                  used_next = used + NW'(1);
                end else if ((rdata != '0) && (rq_nc == '0)) begin
                  used_next = used - NW'(1);
                end
                if ((rq_nc == '0) && (LW'(hint) > b_ext)) begin
                  hint_next = b_ext[NW-1:0];
                end
              end
              default: begin
                c_new = rdata;
              end
            endcase
            wdata   = c_new;
            res.cnt = CNT_W'(c_new);
          end
        end
        default: begin
          res.status = ST_OK;
        end
      endcase
    end
    res.shared = res.cnt > CNT_W'(1);
    free_full  = n_ext - LW'(used_next);
    res.free   = free_full[BIU_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin       <= BIU_RESET;
      hint      <= '0;
      used      <= '0;
      ptr       <= '0;
      chk_valid <= 1'b0;
    end else if (cmd.cfg_wr) begin
      bin       <= blocks_in_use;
      ptr       <= new_n_ext[NW-1:0];
      chk_valid <= 1'b0;
      if (LW'(hint) > new_n_ext) begin
        hint <= new_n_ext[NW-1:0];
      end
    end else if (cmd.accept) begin
      ptr       <= hint;
      chk_valid <= 1'b0;
    end else begin
      hint <= hint_next;
      used <= used_next;
      if (cmd.clr_en) begin
        ptr <= ptr + NW'(1);
      end else if (cmd.scan) begin
        if (!found && !ptr_at_n) begin
          ptr       <= ptr + NW'(1);
          chk_valid <= 1'b1;
        end else begin
          chk_valid <= 1'b0;
        end
      end else if (cmd.sweep) begin
        if (!ptr_at_lim) begin
          ptr       <= ptr + NW'(1);
          chk_valid <= 1'b1;
        end else begin
          chk_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cfg_wr) begin
      lim <= n_ext[NW-1:0];
    end
    if (cmd.accept) begin
      rq_type <= req_type;
      rq_b    <= block_index;
      rq_nc   <= new_count[COUNT_BITS-1:0];
    end
    if ((cmd.scan || cmd.sweep) && !ptr_at_n) begin
      chk_addr <= ptr[AW-1:0];
    end else if (cmd.sweep) begin
      chk_addr <= ptr[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (fin) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        pend_valid <= 1'b1;
      end
    end else if (pend_valid && (!out_valid || take)) begin
      out_valid  <= 1'b1;
      pend_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      if (!out_valid || take) begin
        out_res <= res;
      end else begin
        pend_res <= res;
      end
    end else if (pend_valid && (!out_valid || take)) begin
      out_res <= pend_res;
    end
  end

endmodule

// ===== design/refcount_block_allocator.sv =====
// Top level of the reference-counted first-fit block allocator.
// Depends on rba_pkg, rba_ctrl and rba_datapath.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------------
//   input   | in_valid, in_stall   | req_type, block_index, new_count
//   result  | out_valid, out_stall | status, result_block, result_count, is_shared,
//           |                      | free_blocks
//   config  | cfg_valid, cfg_ready | blocks_in_use
//
// A count request reads its count when accepted and writes any new count back in S_RMW.
// An allocation scans up from the hint to the first free entry or the end of the managed
// range. After reset the count memory is cleared one entry a cycle with in_stall high
// and cfg_ready low. Shrinking blocks_in_use sweeps the dropped entries one a cycle.
// One finished beat may wait in the output register and one more in a holding register
// while the result side stalls; a new request is taken while only one waits.
module refcount_block_allocator #(
  parameter int MAX_BLOCKS = rba_pkg::DEF_MAX_BLOCKS,
  parameter int COUNT_BITS = rba_pkg::DEF_COUNT_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [rba_pkg::REQ_W-1:0] req_type,
  input  logic [rba_pkg::IDX_W-1:0] block_index,
  input  logic [rba_pkg::CNT_W-1:0] new_count,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [rba_pkg::ST_W-1:0]  status,
  output logic [rba_pkg::IDX_W-1:0] result_block,
  output logic [rba_pkg::CNT_W-1:0] result_count,
  output logic                      is_shared,
  output logic [rba_pkg::BIU_W-1:0] free_blocks,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [rba_pkg::BIU_W-1:0] blocks_in_use
);
  import rba_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;
  res_t       out_res;

  rba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .cfg_valid (cfg_valid),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready)
  );

  rba_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .blocks_in_use (blocks_in_use),
    .req_type      (req_type),
    .block_index   (block_index),
    .new_count     (new_count),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_res       (out_res)
  );

  assign status       = out_res.status;
  assign result_block = out_res.blk;
  assign result_count = out_res.cnt;
  assign is_shared    = out_res.shared;
  assign free_blocks  = out_res.free;

  a_no_dual_accept: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && !in_stall && cfg_valid && cfg_ready))
    else $error("request and configuration accepted in the same cycle");

  a_accept_starts_work: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (in_stall && (cmd.rmw || cmd.scan)))
    else $error("accepted request did not start a count update or a scan");

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clr_en, cmd.accept, cmd.cfg_wr, cmd.rmw, cmd.scan, cmd.sweep}))
    else $error("more than one datapath command active");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (in_stall && !cfg_ready && cmd.clr_en))
    else $error("block not clearing the count memory after reset");

endmodule

// ===== verif/tb_refcount_block_allocator.sv =====
// Self-checking testbench for refcount_block_allocator: directed and random count requests
// with random idling on both channels, checked against a predictor of the count table.
// Depends on rba_pkg and the refcount_block_allocator RTL.
`timescale 1ns / 1ps

module tb_refcount_block_allocator;
  import rba_pkg::*;

  class refcount_tracker;
    localparam logic [CNT_W-1:0] COUNT_ALL_ONES = '1;

    logic [CNT_W-1:0] counts [DEF_MAX_BLOCKS];
    int unsigned      hint;
    int unsigned      used;
    int unsigned      blocks;
    res_t             pending_results [$];
    int unsigned      mismatches;
    int unsigned      requests;
    int unsigned      status_seen [5];

    function new();
      foreach (counts[i]) counts[i] = '0;
      hint = 0;
      used = 0;
      blocks = BIU_RESET;
      mismatches = 0;
      requests = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int unsigned managed();
      return (blocks > DEF_MAX_BLOCKS) ? DEF_MAX_BLOCKS : blocks;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // A smaller block count drops the upper entries and pulls the hint down with it.
    function void resize(logic [BIU_W-1:0] value);
      int unsigned old_n;
      int unsigned new_n;
      old_n = managed();
      blocks = value;
      new_n = managed();
      for (int i = new_n; i < old_n; i++) begin
        if (counts[i] != 0) begin
          counts[i] = '0;
          used--;
        end
      end
      if (hint > new_n) hint = new_n;
    endfunction

    function void take_request(logic [REQ_W-1:0] req, logic [IDX_W-1:0] idx,
                               logic [CNT_W-1:0] nc);
      res_t             r;
      int unsigned      n;
      logic [CNT_W-1:0] c;
      n = managed();
      r.status = ST_OK;
      r.blk = idx;
      r.cnt = '0;
      requests++;
      case (req)
        REQ_ALLOC: begin
          r.blk = '0;
          r.status = ST_NOSPACE;
          for (int i = hint; i < n; i++) begin
            if (counts[i] == 0) begin
              counts[i] = 1;
              hint = i + 1;
              used++;
              r.blk = IDX_W'(i);
              r.cnt = 1;
              r.status = ST_OK;
              break;
            end
          end
        end
        REQ_INC, REQ_DEC, REQ_READ, REQ_SET: begin
          if (idx >= n) begin
            r.status = ST_RANGE;
          end else begin
            c = counts[idx];
            if (req == REQ_INC) begin
              if (c == COUNT_ALL_ONES) begin
                r.status = ST_OVER;
              end else begin
                if (c == 0) used++;
                c++;
              end
            end else if (req == REQ_DEC) begin
              if (c == 0) begin
                r.status = ST_UNDER;
              end else begin
                c--;
                if (c == 0) begin
                  used--;
                  if (hint > idx) hint = idx;
                end
              end
            end else if (req == REQ_SET) begin
              if (c == 0 && nc != 0) used++;
              else if (c != 0 && nc == 0) used--;
              if (nc == 0 && hint > idx) hint = idx;
              c = nc;
            end
            counts[idx] = c;
            r.cnt = c;
          end
        end
        default: ;
      endcase
      r.shared = (r.cnt > 1);
      r.free = BIU_W'(n - used);
      pending_results.push_back(r);
    endfunction

    function void note_mismatch(string what);
      mismatches++;
      if (mismatches <= 10) $display("%0t mismatch: %s", $time, what);
    endfunction

    function void check_result(logic [ST_W-1:0] st, logic [IDX_W-1:0] blk,
                               logic [CNT_W-1:0] cnt, logic shr, logic [BIU_W-1:0] fr);
      res_t want;
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result beat, status %0d block %0d count %0h",
                                st, blk, cnt));
        return;
      end
      want = pending_results.pop_front();
      if (want.status <= ST_OVER) status_seen[want.status]++;
      if (st !== want.status)
        note_mismatch($sformatf("status expected %0d got %0d", want.status, st));
      if (blk !== want.blk)
        note_mismatch($sformatf("result_block expected %0d got %0d", want.blk, blk));
      if (cnt !== want.cnt)
        note_mismatch($sformatf("result_count expected %0h got %0h", want.cnt, cnt));
      if (shr !== want.shared)
        note_mismatch($sformatf("is_shared expected %0b got %0b", want.shared, shr));
      if (fr !== want.free)
        note_mismatch($sformatf("free_blocks expected %0d got %0d", want.free, fr));
    endfunction
  endclass

  localparam logic [REQ_W-1:0] REQ_UNDEF_A = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UNDEF_B = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNDEF_C = 3'd7;
  localparam logic [CNT_W-1:0] COUNT_ALL_ONES = '1;

  logic             clk = 1'b0;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic [REQ_W-1:0] req_type;
  logic [IDX_W-1:0] block_index;
  logic [CNT_W-1:0] new_count;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ST_W-1:0]  status;
  logic [IDX_W-1:0] result_block;
  logic [CNT_W-1:0] result_count;
  logic             is_shared;
  logic [BIU_W-1:0] free_blocks;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [BIU_W-1:0] blocks_in_use;

  refcount_tracker  tracker;
  int unsigned      send_idle;
  int unsigned      recv_idle;
  int unsigned      cfg_writes;

  refcount_block_allocator u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .block_index  (block_index),
    .new_count    (new_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .result_block (result_block),
    .result_count (result_count),
    .is_shared    (is_shared),
    .free_blocks  (free_blocks),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .blocks_in_use(blocks_in_use)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.check_result(status, result_block, result_count, is_shared, free_blocks);
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  task automatic send_req(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] idx,
                          input logic [CNT_W-1:0] nc);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    block_index <= idx;
    new_count <= nc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_request(req, idx, nc);
  endtask

  // The block count only changes once every result has come back.
  task automatic write_blocks(input logic [BIU_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    blocks_in_use <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.resize(value);
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int unsigned items);
    logic [REQ_W-1:0] req;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] nc;
    int unsigned      pick;
    int unsigned      span;
    for (int k = 0; k < items; k++) begin
      span = tracker.managed();
      pick = $urandom_range(99);
      if (pick < 30) req = REQ_ALLOC;
      else if (pick < 45) req = REQ_INC;
      else if (pick < 65) req = REQ_DEC;
      else if (pick < 75) req = REQ_READ;
      else if (pick < 93) req = REQ_SET;
      else req = REQ_W'($urandom_range(REQ_UNDEF_C, REQ_UNDEF_A));
      if (span > 0 && $urandom_range(99) < 85) idx = IDX_W'($urandom_range(span - 1, 0));
      else idx = IDX_W'($urandom);
      case ($urandom_range(5))
        0, 1: nc = '0;
        2: nc = $urandom_range(3, 1);
        3: nc = COUNT_ALL_ONES;
        4: nc = COUNT_ALL_ONES - 1;
        default: nc = $urandom;
      endcase
      send_req(req, idx, nc);
    end
  endtask

  initial begin
    tracker = new();
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = REQ_ALLOC;
    block_index = '0;
    new_count = '0;
    cfg_valid = 1'b0;
    blocks_in_use = BIU_RESET;
    cfg_writes = 0;
    send_idle = 21;
    recv_idle = 52;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_req(REQ_ALLOC, '0, '0);
    send_req(REQ_ALLOC, '1, '0);
    send_req(REQ_INC, 10'd0, '0);
    send_req(REQ_READ, 10'd0, '0);
    send_req(REQ_DEC, 10'd1, '0);
    send_req(REQ_DEC, 10'd1, '0);
    send_req(REQ_ALLOC, '0, '0);
    send_req(REQ_SET, 10'd1023, COUNT_ALL_ONES);
    send_req(REQ_INC, 10'd1023, '0);
    send_req(REQ_SET, 10'd1023, '0);
    send_req(REQ_SET, 10'd5, 32'd7);
    send_req(REQ_SET, 10'd5, 32'd3);
    send_req(REQ_SET, 10'd5, '0);
    send_req(REQ_DEC, 10'd0, '0);
    send_req(REQ_READ, 10'd1023, '0);
    send_req(REQ_UNDEF_A, 10'd1023, COUNT_ALL_ONES);
    send_req(REQ_UNDEF_B, 10'd0, 32'h5555_5555);
    send_req(REQ_UNDEF_C, 10'h2aa, 32'haaaa_aaaa);
    send_req(REQ_SET, 10'd1022, 32'h5555_5555);
    write_blocks(11'd4);
    send_req(REQ_INC, 10'd4, '0);
    send_req(REQ_READ, 10'd1022, '0);
    send_req(REQ_ALLOC, '0, '0);
    send_req(REQ_ALLOC, '0, '0);
    send_req(REQ_ALLOC, '0, '0);
    write_blocks(11'd0);
    send_req(REQ_ALLOC, '0, '0);
    send_req(REQ_READ, 10'd0, '0);

    for (int mode = 0; mode < 3; mode++) begin
      send_idle = (mode == 0) ? 21 : (mode == 1) ? 52 : 0;
      recv_idle = (mode == 0) ? 52 : (mode == 1) ? 21 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        case (mode * 4 + seg)
          0: write_blocks(11'd16);
          1: write_blocks(11'd1);
          2: write_blocks(11'd1024);
          3: write_blocks(11'd5);
          4: write_blocks(11'd2047);
          5: write_blocks(11'd8);
          6: write_blocks(11'd0);
          7: write_blocks(11'd33);
          8: write_blocks(11'd64);
          9: write_blocks(11'd2);
          10: write_blocks(11'd1000);
          default: write_blocks(11'd12);
        endcase
        run_random(170);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Ran %0d requests across %0d block-count writes (0, 1, 1024 and 2047 among them).",
             tracker.requests, cfg_writes);
    $display("Results by status: ok %0d, range %0d, no space %0d, underflow %0d, overflow %0d.",
             tracker.status_seen[ST_OK], tracker.status_seen[ST_RANGE],
             tracker.status_seen[ST_NOSPACE], tracker.status_seen[ST_UNDER],
             tracker.status_seen[ST_OVER]);
    if (tracker.mismatches == 0) begin
      $display("[refcount_block_allocator] OK");
    end else begin
      $display("%0d mismatches in total", tracker.mismatches);
      $display("[refcount_block_allocator] ERROR");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("Timed out with %0d results still pending.", tracker.pending());
    $display("[refcount_block_allocator] ERROR");
    $finish;
  end
endmodule
